[sv/ftsc_pkg.sv]
package ftsc_pkg;

    localparam int ADC_BITS_DEF = 12;

    // register and field widths
    localparam int TICK_W     = 24;
    localparam int PPT_W      = 4;
    localparam int FSR_W      = 16;
    localparam int DUTY_W     = 10;
    localparam int GAIN_W     = 8;
    localparam int SDIV_W     = 8;
    localparam int PERIOD_W   = 32;
    localparam int RPM_W      = 32;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [TICK_W-1:0] TICK_RST  = TICK_W'(1000000);
    localparam logic [PPT_W-1:0]  PPT_RST   = PPT_W'(2);
    localparam logic [FSR_W-1:0]  FSR_RST   = FSR_W'(2500);
    localparam logic [DUTY_W-1:0] FLOOR_RST = DUTY_W'(420);
    localparam logic [DUTY_W-1:0] CEIL_RST  = DUTY_W'(1000);
    localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(10);
    localparam logic [SDIV_W-1:0] SDIV_RST  = SDIV_W'(5);

    // scale factors
    localparam int TEMP_SPAN    = 330;
    localparam int SET_SPAN     = 150;
    localparam int RPM_SCALE    = 60;
    localparam int PCT_SCALE    = 100;
    localparam int PCT_MAX      = 100;
    localparam int DUTY_PER_PCT = 10;

    // tach arithmetic widths
    localparam int NUM_W  = TICK_W + 6;        // 60 * tick
    localparam int DEN_W  = PPT_W + PERIOD_W;  // pulses * period
    localparam int PROD_W = NUM_W + 7;         // rpm * 100

    // shared divider
    localparam int DIV_NW = PROD_W;
    localparam int DIV_DW = DEN_W;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // speed error path
    localparam int ERR_W  = DUTY_W + 2;
    localparam int EMAG_W = DUTY_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_RATE  = 3'd0,
        REG_PULSES     = 3'd1,
        REG_FULL_RPM   = 3'd2,
        REG_DUTY_FLOOR = 3'd3,
        REG_DUTY_CEIL  = 3'd4,
        REG_TEMP_GAIN  = 3'd5,
        REG_SPEED_DIV  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_RPM,
        DIV_PCT,
        DIV_DEM,
        DIV_ERR
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TACH,
        S_RPM_START,
        S_RPM_WAIT,
        S_PCT_START,
        S_PCT_WAIT,
        S_ADC,
        S_GAIN,
        S_DEM_CHK,
        S_DEM_WAIT,
        S_ERR_START,
        S_ERR_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     tach_mul;
        logic     div_start;
        div_sel_t div_sel;
        logic     rpm_load;
        logic     pct_load;
        logic     diff_mul;
        logic     gain_mul;
        logic     dem_load;
        logic     duty_load;
        logic     duty_zero;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tach_go;
        logic adc_go;
        logic d_pos;
        logic div_done;
    } dp_status_t;

endpackage

[sv/ftsc_div.sv]
module ftsc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ftsc_pkg::DIV_NW-1:0] numer,
    input  logic [ftsc_pkg::DIV_DW-1:0] denom,
    input  logic [ftsc_pkg::DIV_CW-1:0] count,
    output logic                        done,
    output logic [ftsc_pkg::DIV_NW-1:0] quotient
);
    import ftsc_pkg::*;

    // numerator arrives left-aligned; count bits are shifted through,
    // leaving the quotient in the low count bits of q_reg
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [DIV_NW-1:0]   q_reg;
    logic [DIV_DW-1:0]   rem_reg;
    logic [DIV_DW-1:0]   den_reg;
    logic [DIV_DW:0]     shifted;
    logic [DIV_DW+1:0]   trial;
    logic                neg;

    assign shifted = {rem_reg, q_reg[DIV_NW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign neg     = trial[DIV_DW+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = count;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - DIV_CW'(1);
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_NW-2:0], ~neg};
            rem_reg <= neg ? shifted[DIV_DW-1:0] : trial[DIV_DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[sv/ftsc_dp.sv]
module ftsc_dp #(
    parameter int ADC_BITS = ftsc_pkg::ADC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ftsc_pkg::ctrl_cmd_t             cmd,
    output ftsc_pkg::dp_status_t            status,
    input  logic [ADC_BITS-1:0]             temp_code,
    input  logic [ADC_BITS-1:0]             setpoint_code,
    input  logic                            adc_ready,
    input  logic [ftsc_pkg::PERIOD_W-1:0]   tach_period,
    input  logic                            tach_new,
    input  logic                            cfg_wr_en,
    input  logic [ftsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ftsc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [ftsc_pkg::DUTY_W-1:0]     duty,
    output logic [ftsc_pkg::RPM_W-1:0]      fan_rpm,
    output logic [ftsc_pkg::PCT_W-1:0]      speed_percent
);
    import ftsc_pkg::*;

    localparam int TS_W    = ADC_BITS + 9;          // code * 330
    localparam int DIFF_W  = ADC_BITS + 10;
    localparam int D_W     = GAIN_W + 1 + DIFF_W;
    localparam int DMAG_W  = D_W - 1;
    localparam int DEMQ_W  = DMAG_W - ADC_BITS + 1;
    localparam int DEM_W   = DEMQ_W + 1;
    localparam int SUM_W   = DUTY_W + 3;
    localparam int PCT10_W = PCT_W + 4;
    localparam logic [DIV_DW-1:0] ADC_FULL = DIV_DW'((64'd1 << ADC_BITS) - 64'd1);

    // configuration
    logic [TICK_W-1:0] tick_reg;
    logic [PPT_W-1:0]  ppt_reg;
    logic [FSR_W-1:0]  fsr_reg;
    logic [DUTY_W-1:0] floor_reg;
    logic [DUTY_W-1:0] ceil_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [SDIV_W-1:0] sdiv_reg;

    // captured item
    logic [ADC_BITS-1:0] temp_reg;
    logic [ADC_BITS-1:0] set_reg;
    logic                adc_rdy_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                tach_new_reg;

    // state
    logic [RPM_W-1:0]  rpm_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [DUTY_W-1:0] duty_reg;

    // intermediates
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [NUM_W-1:0]         rpm_tmp_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [D_W-1:0]    d_reg;
    logic signed [ERR_W-1:0]  err_reg;

    // output register
    logic [DUTY_W-1:0] duty_out_reg;
    logic [RPM_W-1:0]  rpm_out_reg;
    logic [PCT_W-1:0]  pct_out_reg;

    logic [PPT_W-1:0]  ppt1;
    logic [FSR_W-1:0]  fsr1;
    logic [SDIV_W-1:0] sdiv1;

    logic [DIV_NW-1:0] div_numer;
    logic [DIV_DW-1:0] div_denom;
    logic [DIV_CW-1:0] div_count;
    logic              div_done;
    logic [DIV_NW-1:0] div_q;

    logic [TS_W-1:0]          t_scaled;
    logic [TS_W-1:0]          s_scaled;
    logic signed [D_W-1:0]    d_mul;
    logic [DMAG_W-1:0]        d_mag;
    logic [PCT_W-1:0]         pct_new;
    logic [DEM_W-1:0]         dem_sum;
    logic [DUTY_W-1:0]        demand;
    logic [PCT10_W-1:0]       pct10;
    logic [EMAG_W-1:0]        err_mag;
    logic [EMAG_W-1:0]        step_mag;
    logic signed [SUM_W-1:0]  step;
    logic signed [SUM_W-1:0]  duty_sum;
    logic signed [SUM_W-1:0]  duty_lo;
    logic [DUTY_W-1:0]        duty_new;

    assign ppt1  = (ppt_reg == '0) ? PPT_W'(1) : ppt_reg;
    assign fsr1  = (fsr_reg == '0) ? FSR_W'(1) : fsr_reg;
    assign sdiv1 = (sdiv_reg == '0) ? SDIV_W'(1) : sdiv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= TICK_RST;
            ppt_reg   <= PPT_RST;
            fsr_reg   <= FSR_RST;
            floor_reg <= FLOOR_RST;
            ceil_reg  <= CEIL_RST;
            gain_reg  <= GAIN_RST;
            sdiv_reg  <= SDIV_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TICK_RATE:  tick_reg  <= cfg_data[TICK_W-1:0];
                REG_PULSES:     ppt_reg   <= cfg_data[PPT_W-1:0];
                REG_FULL_RPM:   fsr_reg   <= cfg_data[FSR_W-1:0];
                REG_DUTY_FLOOR: floor_reg <= cfg_data[DUTY_W-1:0];
                REG_DUTY_CEIL:  ceil_reg  <= cfg_data[DUTY_W-1:0];
                REG_TEMP_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_SPEED_DIV:  sdiv_reg  <= cfg_data[SDIV_W-1:0];
                default: ;
            endcase
        end
    end

    // divider operand select, numerators left-aligned
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_RPM:
            begin
                div_numer = {num_reg, {(DIV_NW - NUM_W){1'b0}}};
                div_denom = den_reg;
                div_count = DIV_CW'(NUM_W);
            end
            DIV_PCT:
            begin
                div_numer = prod_reg;
                div_denom = DIV_DW'(fsr1);
                div_count = DIV_CW'(PROD_W);
            end
            DIV_DEM:
            begin
                div_numer = {d_mag, {(DIV_NW - DMAG_W){1'b0}}};
                div_denom = ADC_FULL;
                div_count = DIV_CW'(DMAG_W);
            end
            default:
            begin
                div_numer = {err_mag, {(DIV_NW - EMAG_W){1'b0}}};
                div_denom = DIV_DW'(sdiv1);
                div_count = DIV_CW'(EMAG_W);
            end
        endcase
    end

    ftsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .count    (div_count),
        .done     (div_done),
        .quotient (div_q)
    );

    assign t_scaled = TS_W'(temp_reg) * TS_W'(TEMP_SPAN);
    assign s_scaled = TS_W'(set_reg) * TS_W'(SET_SPAN);
    assign d_mul    = $signed({1'b0, gain_reg}) * diff_reg;
    assign d_mag    = d_reg[DMAG_W-1:0];

    assign pct_new = (div_q > DIV_NW'(PCT_MAX)) ? PCT_W'(PCT_MAX) : div_q[PCT_W-1:0];

    assign dem_sum = DEM_W'(floor_reg) + DEM_W'(div_q[DEMQ_W-1:0]);
    assign demand  = (dem_sum > DEM_W'(ceil_reg)) ? ceil_reg : dem_sum[DUTY_W-1:0];
    assign pct10   = PCT10_W'(pct_reg) * PCT10_W'(DUTY_PER_PCT);

    assign err_mag  = err_reg[ERR_W-1] ? EMAG_W'(-err_reg) : EMAG_W'(err_reg);
    assign step_mag = div_q[EMAG_W-1:0];
    assign step     = err_reg[ERR_W-1] ? -$signed({2'b00, step_mag})
                                       : $signed({2'b00, step_mag});
    assign duty_sum = $signed({3'b000, duty_reg}) + step;

    // floor first, ceiling last
    always_comb
    begin
        duty_lo = duty_sum;
        if (duty_sum < $signed({3'b000, floor_reg}))
        begin
            duty_lo = $signed({3'b000, floor_reg});
        end
        duty_new = duty_lo[DUTY_W-1:0];
        if (duty_lo > $signed({3'b000, ceil_reg}))
        begin
            duty_new = ceil_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_reg  <= '0;
            pct_reg  <= '0;
            duty_reg <= '0;
        end
        else
        begin
            if (cmd.pct_load)
            begin
                rpm_reg <= RPM_W'(rpm_tmp_reg);
                pct_reg <= pct_new;
            end
            if (cmd.duty_zero)
            begin
                duty_reg <= '0;
            end
            else if (cmd.duty_load)
            begin
                duty_reg <= duty_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            temp_reg     <= temp_code;
            set_reg      <= setpoint_code;
            adc_rdy_reg  <= adc_ready;
            period_reg   <= tach_period;
            tach_new_reg <= tach_new;
        end
        if (cmd.tach_mul)
        begin
            num_reg <= NUM_W'(tick_reg) * NUM_W'(RPM_SCALE);
            den_reg <= DEN_W'(ppt1) * DEN_W'(period_reg);
        end
        if (cmd.rpm_load)
        begin
            rpm_tmp_reg <= div_q[NUM_W-1:0];
            prod_reg    <= PROD_W'(div_q[NUM_W-1:0]) * PROD_W'(PCT_SCALE);
        end
        if (cmd.diff_mul)
        begin
            diff_reg <= $signed({1'b0, t_scaled}) - $signed({1'b0, s_scaled});
        end
        if (cmd.gain_mul)
        begin
            d_reg <= d_mul;
        end
        if (cmd.dem_load)
        begin
            err_reg <= $signed({2'b00, demand}) - $signed({1'b0, pct10});
        end
        if (cmd.out_load)
        begin
            duty_out_reg <= duty_reg;
            rpm_out_reg  <= rpm_reg;
            pct_out_reg  <= pct_reg;
        end
    end

    assign status.tach_go  = tach_new_reg && (period_reg != '0);
    assign status.adc_go   = adc_rdy_reg;
    assign status.d_pos    = !d_reg[D_W-1] && (d_reg != '0);
    assign status.div_done = div_done;

    assign duty          = duty_out_reg;
    assign fan_rpm       = rpm_out_reg;
    assign speed_percent = pct_out_reg;

endmodule

[sv/ftsc_ctrl.sv]
module ftsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ftsc_pkg::dp_status_t status,
    output ftsc_pkg::ctrl_cmd_t  cmd
);
    import ftsc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_TACH;
            S_TACH:      state_next = status.tach_go ? S_RPM_START : S_ADC;
            S_RPM_START: state_next = S_RPM_WAIT;
            S_RPM_WAIT:  if (status.div_done) state_next = S_PCT_START;
            S_PCT_START: state_next = S_PCT_WAIT;
            S_PCT_WAIT:  if (status.div_done) state_next = S_ADC;
            S_ADC:       state_next = status.adc_go ? S_GAIN : S_DONE;
            S_GAIN:      state_next = S_DEM_CHK;
            S_DEM_CHK:   state_next = status.d_pos ? S_DEM_WAIT : S_DONE;
            S_DEM_WAIT:  if (status.div_done) state_next = S_ERR_START;
            S_ERR_START: state_next = S_ERR_WAIT;
            S_ERR_WAIT:  if (status.div_done) state_next = S_DONE;
            S_DONE:      if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_TACH:      cmd.tach_mul = status.tach_go;
            S_RPM_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_RPM;
            end
            S_RPM_WAIT:  cmd.rpm_load = status.div_done;
            S_PCT_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PCT;
            end
            S_PCT_WAIT:  cmd.pct_load = status.div_done;
            S_ADC:       cmd.diff_mul = status.adc_go;
            S_GAIN:      cmd.gain_mul = 1'b1;
            S_DEM_CHK:
            begin
                cmd.div_start = status.d_pos;
                cmd.div_sel   = DIV_DEM;
                cmd.duty_zero = !status.d_pos;
            end
            S_DEM_WAIT:  cmd.dem_load = status.div_done;
            S_ERR_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ERR;
            end
            S_ERR_WAIT:  cmd.duty_load = status.div_done;
            S_DONE:      cmd.out_load = !out_valid_reg || out_ready;
            default:     cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/fan_thermal_speed_controller.sv]
// Fan thermal speed controller: one control pass per input transfer.
// Input channel (in_valid/in_ready) carries the temperature and setpoint ADC
// codes with adc_ready, and a tach period with tach_new. Output channel
// (out_valid/out_ready) returns duty, fan_rpm and speed_percent after the
// pass, one result per input item. Configuration is a write-only port
// (cfg_wr_en, cfg_index, cfg_data), taken at any edge with cfg_wr_en high.
// Items are processed one at a time. A pass with neither tach nor ADC work
// only steps through the tach check, the ADC check and the done state; the
// tach update and the duty update add further divider runs. The pass time
// is set by one shared restoring divider retiring one quotient bit per cycle,
// used for the rpm, percent, demand and speed-step quotients in turn.
// The result sits in an output register; the next item is taken as soon as
// the result is loaded there, so a stalled receiver holds the block only
// once the following pass is also finished. Reset restores the default
// configuration and clears internal duty, rpm and percent (not the outputs).
module fan_thermal_speed_controller #(
    parameter int ADC_BITS = ftsc_pkg::ADC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ADC_BITS-1:0]             temp_code,
    input  logic [ADC_BITS-1:0]             setpoint_code,
    input  logic                            adc_ready,
    input  logic [ftsc_pkg::PERIOD_W-1:0]   tach_period,
    input  logic                            tach_new,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ftsc_pkg::DUTY_W-1:0]     duty,
    output logic [ftsc_pkg::RPM_W-1:0]      fan_rpm,
    output logic [ftsc_pkg::PCT_W-1:0]      speed_percent,
    input  logic                            cfg_wr_en,
    input  logic [ftsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ftsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ftsc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ftsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ftsc_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .temp_code     (temp_code),
        .setpoint_code (setpoint_code),
        .adc_ready     (adc_ready),
        .tach_period   (tach_period),
        .tach_new      (tach_new),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .duty          (duty),
        .fan_rpm       (fan_rpm),
        .speed_percent (speed_percent)
    );

endmodule

[sv/ftsc_chk.sv]
module ftsc_chk #(
    parameter int ADC_BITS = ftsc_pkg::ADC_BITS_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [ADC_BITS-1:0]             temp_code,
    input logic [ADC_BITS-1:0]             setpoint_code,
    input logic                            adc_ready,
    input logic [ftsc_pkg::PERIOD_W-1:0]   tach_period,
    input logic                            tach_new,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [ftsc_pkg::DUTY_W-1:0]     duty,
    input logic [ftsc_pkg::RPM_W-1:0]      fan_rpm,
    input logic [ftsc_pkg::PCT_W-1:0]      speed_percent,
    input logic                            cfg_wr_en,
    input logic [ftsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [ftsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ftsc_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty)
            && $stable(fan_rpm) && $stable(speed_percent))
        else $error("result changed while stalled");

    // percent is clamped
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed_percent <= PCT_W'(PCT_MAX))
        else $error("speed_percent above limit");

    // one item in flight: a transfer closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input open while item in flight");

    // a new result is posted only as the pass ends
    a_post_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result posted mid-pass");

endmodule

bind fan_thermal_speed_controller ftsc_chk #(.ADC_BITS(ADC_BITS)) u_chk (.*);
